@@ rtl/bll_pkg.sv @@
`default_nettype none

package bll_pkg;

    // coordinate and register widths
    localparam int COORD_BITS = 6;
    localparam int REG_BITS   = COORD_BITS + 1;
    localparam int ERR_BITS   = COORD_BITS + 3;
    localparam int CFG_IDX_BITS = 2;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMG_HEIGHT = 2'd1;

    // reset value of the image size registers
    localparam logic [REG_BITS-1:0] IMG_SIZE_RESET = REG_BITS'(1 << COORD_BITS);

    // line request
    typedef struct packed {
        logic [COORD_BITS-1:0] x_start;
        logic [COORD_BITS-1:0] y_start;
        logic [COORD_BITS-1:0] x_end;
        logic [COORD_BITS-1:0] y_end;
    } t_req;

    // one emitted pixel
    typedef struct packed {
        logic [COORD_BITS-1:0] pix_x;
        logic [COORD_BITS-1:0] pix_y;
        logic                  inside_res;
        logic                  last;
    } t_res;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic last;
    } t_sts;

endpackage

`default_nettype wire

@@ rtl/bresenham_line_rasterizer.sv @@
// Bresenham line rasterizer, all octants.
// A line request is taken at a clock edge with start high and busy low; the
// request carries both endpoints. The block then walks the segment from the
// first endpoint to the second and emits one pixel per cycle on o_res, each
// marked by a one-cycle o_res_valid. Every pixel carries inside_res (clear
// when x >= image width or y >= image height) and last, set on the final one.
// The request is loaded into the walk registers, and each pixel passes from
// them through the output register before it shows on o_res.
// A segment of major-axis length d gives d+1 pixels on consecutive cycles;
// busy drops with the last pixel step, and a new request is taken only while
// busy is low, so the block cannot take a new request before it is through
// with the last; the single pixel-step loop makes one error update per cycle.
// The receiver cannot stall: each pixel is shown for exactly one cycle.
// The image size registers (index 0 width, index 1 height) are written
// through i_cfg_we/i_cfg_idx/i_cfg_data; the user must do so while busy is
// low, which the block does not enforce; other indexes are ignored. Reset
// (synchronous, active low) returns the block to idle and sets both sizes to 64.
`default_nettype none

module bresenham_line_rasterizer (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                start,
    output logic                               busy,
    input  bll_pkg::t_req                      i_req,
    output bll_pkg::t_res                      o_res,
    output logic                               o_res_valid,
    input  wire                                i_cfg_we,
    input  wire [bll_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  wire [bll_pkg::REG_BITS-1:0]        i_cfg_data
);

    logic [bll_pkg::REG_BITS-1:0] r_img_width;
    logic [bll_pkg::REG_BITS-1:0] r_img_height;
    bll_pkg::t_cmd cmd;
    bll_pkg::t_sts sts;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_width  <= bll_pkg::IMG_SIZE_RESET;
            r_img_height <= bll_pkg::IMG_SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bll_pkg::CFG_IMG_WIDTH:  r_img_width  <= i_cfg_data;
                bll_pkg::CFG_IMG_HEIGHT: r_img_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    bll_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // walk datapath
    bll_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_req        (i_req),
        .i_img_width  (r_img_width),
        .i_img_height (r_img_height),
        .o_sts        (sts),
        .o_res        (o_res),
        .o_res_valid  (o_res_valid)
    );

`ifndef ASSERT_OFF
    a_start_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");
    a_last_frees_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.last) |-> !busy)
        else $error("busy still high with last pixel out");
`endif

endmodule

`default_nettype wire

@@ rtl/bll_ctrl.sv @@
`default_nettype none

module bll_ctrl (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  bll_pkg::t_sts i_sts,
    output bll_pkg::t_cmd o_cmd,
    output logic        o_busy
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WALK = 1'b1;

    logic r_state;
    logic n_state;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (i_sts.last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // commands to the datapath
    assign o_cmd.load = (r_state == S_IDLE) && i_start;
    assign o_cmd.step = (r_state == S_WALK);
    assign o_busy     = (r_state == S_WALK);

`ifndef ASSERT_OFF
    a_no_load_while_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.load && o_cmd.step))
        else $error("load and step issued together");
    a_last_ends_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.step && i_sts.last) |=> (r_state == S_IDLE))
        else $error("walk did not end after last pixel");
`endif

endmodule

`default_nettype wire

@@ rtl/bll_dp.sv @@
`default_nettype none

module bll_dp (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  bll_pkg::t_cmd                 i_cmd,
    input  bll_pkg::t_req                 i_req,
    input  wire [bll_pkg::REG_BITS-1:0]   i_img_width,
    input  wire [bll_pkg::REG_BITS-1:0]   i_img_height,
    output bll_pkg::t_sts                 o_sts,
    output bll_pkg::t_res                 o_res,
    output logic                          o_res_valid
);

    localparam int CB = bll_pkg::COORD_BITS;
    localparam int EB = bll_pkg::ERR_BITS;

    logic [CB-1:0] r_x, r_y, r_cnt;
    logic signed [EB-1:0] r_err, r_inc_a, r_inc_b;
    logic r_xdown, r_ydown, r_ymajor;
    bll_pkg::t_res r_res;
    logic r_res_valid;

    logic [CB-1:0] adx, ady, dmaj, dmin;
    logic ymaj;
    logic [EB-1:0] two_dmin, two_dmaj;
    logic err_pos;
    logic [CB-1:0] x_stepped, y_stepped;

    // setup of a new segment
    always_comb begin
        adx  = (i_req.x_end >= i_req.x_start) ? (i_req.x_end - i_req.x_start)
                                              : (i_req.x_start - i_req.x_end);
        ady  = (i_req.y_end >= i_req.y_start) ? (i_req.y_end - i_req.y_start)
                                              : (i_req.y_start - i_req.y_end);
        ymaj = ady > adx;
        dmaj = ymaj ? ady : adx;
        dmin = ymaj ? adx : ady;
        two_dmin = {2'b00, dmin, 1'b0};
        two_dmaj = {2'b00, dmaj, 1'b0};
    end

    // per-pixel decision
    assign err_pos   = !r_err[EB-1] && (r_err != '0);
    assign x_stepped = r_xdown ? (r_x - 1'b1) : (r_x + 1'b1);
    assign y_stepped = r_ydown ? (r_y - 1'b1) : (r_y + 1'b1);

    // walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x      <= i_req.x_start;
            r_y      <= i_req.y_start;
            r_cnt    <= dmaj;
            r_xdown  <= i_req.x_end < i_req.x_start;
            r_ydown  <= i_req.y_end < i_req.y_start;
            r_ymajor <= ymaj;
            r_err    <= two_dmin - {3'b000, dmaj};
            r_inc_a  <= two_dmin;
            r_inc_b  <= two_dmin - two_dmaj;
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt - 1'b1;
            r_err <= r_err + (err_pos ? r_inc_b : r_inc_a);
            if (r_ymajor) begin
                r_y <= y_stepped;
                if (err_pos) begin
                    r_x <= x_stepped;
                end
            end else begin
                r_x <= x_stepped;
                if (err_pos) begin
                    r_y <= y_stepped;
                end
            end
        end
    end

    // output register, one pixel per step
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_res.pix_x      <= r_x;
            r_res.pix_y      <= r_y;
            r_res.inside_res <= ({1'b0, r_x} < i_img_width) && ({1'b0, r_y} < i_img_height);
            r_res.last       <= (r_cnt == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= i_cmd.step;
        end
    end

    assign o_sts.last  = (r_cnt == '0);
    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;

`ifndef ASSERT_OFF
    a_valid_follows_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |=> o_res_valid)
        else $error("pixel not presented after step");
    a_count_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && !o_sts.last) |=> (r_cnt == $past(r_cnt) - 1'b1))
        else $error("pixel counter did not advance");
`endif

endmodule

`default_nettype wire

@@ verif/bresenham_line_rasterizer_test.sv @@
`default_nettype none

module bresenham_line_rasterizer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bll_pkg::*;

    localparam int RESET_CYCLES   = 10;
    localparam int MAX_GAP        = 12;
    localparam int DRAIN_SETTLE   = 4;
    localparam int TAIL_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RAND_PHASES    = 9;
    localparam int PHASE_LINES    = 50;

    // indexes past the two image size registers, writes there are dropped
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = 2'd3;

    typedef enum logic [1:0] {
        ENT_LINE,
        ENT_CFG,
        ENT_DRAIN
    } t_ent_kind;

    typedef struct {
        t_ent_kind                kind;
        t_req                     req;
        logic [CFG_IDX_BITS-1:0]  idx;
        logic [REG_BITS-1:0]      data;
        int                       gap;
    } t_entry;

    // clock and block ports
    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    t_req                     i_req = '0;
    t_res                     o_res;
    logic                     o_res_valid;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx = '0;
    logic [REG_BITS-1:0]      i_cfg_data = '0;

    // driver side
    t_entry                   line_feed[$];
    t_entry                   cur_ent;
    bit                       holding = 1'b0;
    int                       gap_left = 0;
    int                       settle = 0;
    logic                     feed_done = 1'b0;

    // checker side
    t_res                     pixels_due[$];
    logic [REG_BITS-1:0]      size_w = IMG_SIZE_RESET;
    logic [REG_BITS-1:0]      size_h = IMG_SIZE_RESET;
    int                       due_count = 0;
    int                       fault_cnt = 0;
    int                       idle_cycles = 0;

    bresenham_line_rasterizer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_res       (o_res),
        .o_res_valid (o_res_valid),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // walk one segment and queue every pixel it should produce
    function automatic void trace_line(input t_req rq);
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
        int   adx;
        int   ady;
        int   dmaj;
        int   dmin;
        int   err;
        bit   xdown;
        bit   ydown;
        bit   ymajor;
        t_res pix;
        adx = (rq.x_end >= rq.x_start) ? int'(rq.x_end) - int'(rq.x_start)
                                       : int'(rq.x_start) - int'(rq.x_end);
        ady = (rq.y_end >= rq.y_start) ? int'(rq.y_end) - int'(rq.y_start)
                                       : int'(rq.y_start) - int'(rq.y_end);
        xdown  = rq.x_end < rq.x_start;
        ydown  = rq.y_end < rq.y_start;
        ymajor = ady > adx;
        dmaj   = ymajor ? ady : adx;
        dmin   = ymajor ? adx : ady;
        px     = rq.x_start;
        py     = rq.y_start;
        err    = 2 * dmin - dmaj;
        for (int k = 0; k <= dmaj; k++) begin
            pix.pix_x      = px;
            pix.pix_y      = py;
            pix.inside_res = (int'(px) < int'(size_w)) && (int'(py) < int'(size_h));
            pix.last       = (k == dmaj);
            pixels_due.push_back(pix);
            if (k == dmaj)
                break;
            // minor axis step when the error term goes positive
            if (err > 0) begin
                if (ymajor)
                    px = xdown ? px - 1'b1 : px + 1'b1;
                else
                    py = ydown ? py - 1'b1 : py + 1'b1;
                err -= 2 * dmaj;
            end
            err += 2 * dmin;
            if (ymajor)
                py = ydown ? py - 1'b1 : py + 1'b1;
            else
                px = xdown ? px - 1'b1 : px + 1'b1;
        end
    endfunction

    function automatic void push_line(input int x0, input int y0, input int x1, input int y1,
                                      input int gap);
        t_entry e;
        e.kind        = ENT_LINE;
        e.req.x_start = x0[COORD_BITS-1:0];
        e.req.y_start = y0[COORD_BITS-1:0];
        e.req.x_end   = x1[COORD_BITS-1:0];
        e.req.y_end   = y1[COORD_BITS-1:0];
        e.idx         = '0;
        e.data        = '0;
        e.gap         = gap;
        line_feed.push_back(e);
    endfunction

    function automatic void push_cfg(input logic [CFG_IDX_BITS-1:0] idx, input int value);
        t_entry e;
        e.kind = ENT_CFG;
        e.req  = '0;
        e.idx  = idx;
        e.data = value[REG_BITS-1:0];
        e.gap  = 0;
        line_feed.push_back(e);
    endfunction

    function automatic void push_drain();
        t_entry e;
        e.kind = ENT_DRAIN;
        e.req  = '0;
        e.idx  = '0;
        e.data = '0;
        e.gap  = 0;
        line_feed.push_back(e);
    endfunction

    // image size draw, extremes weighted in
    function automatic int rand_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return 0;
        else if (roll < 20)
            return 1;
        else if (roll < 35)
            return 64;
        else if (roll < 45)
            return 127;
        else if (roll < 80)
            return $urandom_range(1, 64);
        else
            return $urandom_range(0, 127);
    endfunction

    // random segment: free endpoints, plus short, straight, diagonal and point lines
    function automatic void push_rand_line(input int gap);
        logic [COORD_BITS-1:0] x0;
        logic [COORD_BITS-1:0] y0;
        logic [COORD_BITS-1:0] x1;
        logic [COORD_BITS-1:0] y1;
        logic [COORD_BITS-1:0] d;
        int roll;
        x0   = COORD_BITS'($urandom);
        y0   = COORD_BITS'($urandom);
        x1   = COORD_BITS'($urandom);
        y1   = COORD_BITS'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
        end else if (roll < 65) begin
            x1 = x0 + COORD_BITS'($urandom_range(0, 8)) - COORD_BITS'(4);
            y1 = y0 + COORD_BITS'($urandom_range(0, 8)) - COORD_BITS'(4);
        end else if (roll < 75) begin
            y1 = y0;
        end else if (roll < 85) begin
            x1 = x0;
        end else if (roll < 93) begin
            d  = COORD_BITS'($urandom);
            x1 = $urandom_range(0, 1) ? x0 + d : x0 - d;
            y1 = $urandom_range(0, 1) ? y0 + d : y0 - d;
        end else begin
            x1 = x0;
            y1 = y0;
        end
        push_line(int'(x0), int'(y0), int'(x1), int'(y1), gap);
    endfunction

    // driver: one transaction or register write at a time from the feed
    always @(posedge i_clk) begin
        logic                    nxt_start;
        logic                    nxt_we;
        t_req                    nxt_req;
        logic [CFG_IDX_BITS-1:0] nxt_idx;
        logic [REG_BITS-1:0]     nxt_data;
        if (!i_rst_n) begin
            start      <= 1'b0;
            i_req      <= '0;
            i_cfg_we   <= 1'b0;
            i_cfg_idx  <= '0;
            i_cfg_data <= '0;
            feed_done  <= 1'b0;
            holding    = 1'b0;
            gap_left   = 0;
            settle     = 0;
        end else begin
            nxt_start = start;
            nxt_req   = i_req;
            nxt_we    = 1'b0;
            nxt_idx   = i_cfg_idx;
            nxt_data  = i_cfg_data;
            if (start && !busy)
                nxt_start = 1'b0;
            if (!nxt_start && !holding && line_feed.size() != 0) begin
                cur_ent  = line_feed.pop_front();
                holding  = 1'b1;
                gap_left = cur_ent.gap;
                settle   = 0;
            end
            if (holding && !nxt_start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    case (cur_ent.kind)
                        ENT_LINE: begin
                            nxt_start = 1'b1;
                            nxt_req   = cur_ent.req;
                            holding   = 1'b0;
                        end
                        ENT_CFG: begin
                            nxt_we   = 1'b1;
                            nxt_idx  = cur_ent.idx;
                            nxt_data = cur_ent.data;
                            holding  = 1'b0;
                        end
                        ENT_DRAIN: begin
                            // hold off until every pixel is in and the block is idle
                            if (due_count == 0 && !busy) begin
                                if (settle >= DRAIN_SETTLE)
                                    holding = 1'b0;
                                else
                                    settle++;
                            end else begin
                                settle = 0;
                            end
                        end
                        default: holding = 1'b0;
                    endcase
                end
            end
            start      <= nxt_start;
            i_req      <= nxt_req;
            i_cfg_we   <= nxt_we;
            i_cfg_idx  <= nxt_idx;
            i_cfg_data <= nxt_data;
            feed_done  <= !holding && !nxt_start && line_feed.size() == 0;
        end
    end

    // monitor: check pixels, track register writes, predict accepted transactions
    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            size_w = IMG_SIZE_RESET;
            size_h = IMG_SIZE_RESET;
            pixels_due.delete();
            due_count <= 0;
        end else begin
            if (o_res_valid) begin
                if (pixels_due.size() == 0) begin
                    $error("unexpected pixel x %0d y %0d", o_res.pix_x, o_res.pix_y);
                    fault_cnt++;
                end else begin
                    want = pixels_due.pop_front();
                    if (o_res.pix_x !== want.pix_x) begin
                        $error("pix_x expected %0d actual %0d", want.pix_x, o_res.pix_x);
                        fault_cnt++;
                    end
                    if (o_res.pix_y !== want.pix_y) begin
                        $error("pix_y expected %0d actual %0d", want.pix_y, o_res.pix_y);
                        fault_cnt++;
                    end
                    if (o_res.inside_res !== want.inside_res) begin
                        $error("inside_res expected %0b actual %0b", want.inside_res,
                               o_res.inside_res);
                        fault_cnt++;
                    end
                    if (o_res.last !== want.last) begin
                        $error("last expected %0b actual %0b", want.last, o_res.last);
                        fault_cnt++;
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_IMG_WIDTH)
                    size_w = i_cfg_data;
                else if (i_cfg_idx == CFG_IMG_HEIGHT)
                    size_h = i_cfg_data;
            end
            if (start && !busy)
                trace_line(i_req);
            due_count <= pixels_due.size();
        end
    end

    // watchdog on cycles with no transaction, pixel or write
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((start && !busy) || o_res_valid || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus and end of run
    initial begin
        bit no_idle;
        // corners, diagonals and straight lines at the reset image size
        push_line(0, 0, 0, 0, $urandom_range(0, MAX_GAP));
        push_line(63, 63, 63, 63, $urandom_range(0, MAX_GAP));
        push_line(0, 0, 63, 63, $urandom_range(0, MAX_GAP));
        push_line(63, 0, 0, 63, $urandom_range(0, MAX_GAP));
        push_line(0, 63, 63, 0, $urandom_range(0, MAX_GAP));
        push_line(63, 63, 0, 0, 0);
        push_line(0, 5, 63, 5, 0);
        push_line(63, 7, 0, 7, $urandom_range(0, MAX_GAP));
        push_line(9, 0, 9, 63, $urandom_range(0, MAX_GAP));
        push_line(9, 63, 9, 0, 0);
        // lines in six octants, one octant drawn twice
        push_line(10, 10, 40, 20, $urandom_range(0, MAX_GAP));
        push_line(40, 20, 10, 10, $urandom_range(0, MAX_GAP));
        push_line(10, 10, 20, 40, 0);
        push_line(20, 40, 10, 10, $urandom_range(0, MAX_GAP));
        push_line(10, 40, 40, 30, $urandom_range(0, MAX_GAP));
        push_line(30, 10, 20, 50, 0);
        push_line(5, 50, 1, 2, $urandom_range(0, MAX_GAP));

        // zero width clips everything
        push_drain();
        push_cfg(CFG_IMG_WIDTH, 0);
        push_line(0, 0, 5, 3, 0);
        push_line(63, 63, 60, 63, $urandom_range(0, MAX_GAP));
        // zero height
        push_drain();
        push_cfg(CFG_IMG_WIDTH, 64);
        push_cfg(CFG_IMG_HEIGHT, 0);
        push_line(2, 2, 2, 9, 0);
        // oversized sizes clip nothing
        push_drain();
        push_cfg(CFG_IMG_WIDTH, 127);
        push_cfg(CFG_IMG_HEIGHT, 65);
        push_line(63, 0, 0, 63, 0);
        // one by one image
        push_drain();
        push_cfg(CFG_IMG_WIDTH, 1);
        push_cfg(CFG_IMG_HEIGHT, 1);
        push_line(0, 0, 3, 2, 0);
        // spare indexes must leave the sizes alone
        push_drain();
        push_cfg(CFG_SPARE_A, 0);
        push_cfg(CFG_SPARE_B, 127);
        push_line(1, 0, 0, 1, 0);
        // edge of a 63 by 63 image
        push_drain();
        push_cfg(CFG_IMG_WIDTH, 63);
        push_cfg(CFG_IMG_HEIGHT, 63);
        push_line(62, 62, 63, 63, 0);

        // random phases, each with its own image size
        for (int p = 0; p < RAND_PHASES; p++) begin
            push_drain();
            push_cfg(CFG_IMG_WIDTH, rand_size());
            push_cfg(CFG_IMG_HEIGHT, rand_size());
            if ($urandom_range(0, 2) == 0)
                push_cfg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                         $urandom_range(0, 127));
            no_idle = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_LINES; n++) begin
                if ($urandom_range(0, 39) == 0)
                    push_drain();
                push_rand_line(no_idle ? 0 : $urandom_range(0, MAX_GAP));
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all transactions accepted, then all pixels in, then the block idle
        @(posedge i_clk);
        while (!feed_done)
            @(posedge i_clk);
        while (due_count != 0)
            @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fault_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
